// ----- rtl/stable_priority_task_queue_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the stable priority task queue
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_TASK_QUEUE_CORE_ASSERT_SVH
`define STABLE_PRIORITY_TASK_QUEUE_CORE_ASSERT_SVH

// check a property in every cycle
`define SPTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check a consequence in the cycle after a trigger
`define SPTQ_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

// ----- rtl/sptq_pkg.sv -----
// ----------------------------------------------------------------------------
// sptq_pkg
// Opcodes, status codes and command type shared by the queue core and cells.
// ----------------------------------------------------------------------------
package sptq_pkg;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_STOP = 2'd2
  } sptq_op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_REJECTED = 3'd3,
    ST_DRAINED  = 3'd4
  } sptq_status_e;

  typedef struct packed {
    logic push;
    logic pop;
  } sptq_cmd_t;

  localparam int unsigned LevelPortW  = 8;
  localparam int unsigned HandlePortW = 16;
  localparam int unsigned OccPortW    = 6;

endpackage

// ----- rtl/sptq_cell.sv -----
// ----------------------------------------------------------------------------
// sptq_cell
// One slot of the sorted queue: holds a level and handle, flags itself as an
// insertion point for an incoming word, and shifts toward or away from the
// front with its neighbors.
// ----------------------------------------------------------------------------
module sptq_cell import sptq_pkg::*; #(
  parameter int unsigned LEVEL_W = 8,
  parameter int unsigned CNT_W   = 6,
  parameter int unsigned INDEX   = 0
) (
  input  logic                   clk_i,
  input  sptq_cmd_t              cmd_i,
  input  logic [CNT_W-1:0]       count_i,
  input  logic [LEVEL_W-1:0]     new_lvl_i,
  input  logic [HandlePortW-1:0] new_hdl_i,
  input  logic                   prev_ins_i,
  input  logic [LEVEL_W-1:0]     prev_lvl_i,
  input  logic [HandlePortW-1:0] prev_hdl_i,
  input  logic [LEVEL_W-1:0]     next_lvl_i,
  input  logic [HandlePortW-1:0] next_hdl_i,
  output logic                   ins_o,
  output logic [LEVEL_W-1:0]     lvl_o,
  output logic [HandlePortW-1:0] hdl_o
);

  logic [LEVEL_W-1:0]     lvl_q, lvl_d;
  logic [HandlePortW-1:0] hdl_q, hdl_d;
  logic                   empty_slot;

  assign empty_slot = (count_i <= CNT_W'(INDEX));
  assign ins_o      = empty_slot || (lvl_q > new_lvl_i);

  always_comb begin
    lvl_d = lvl_q;
    hdl_d = hdl_q;
    if (cmd_i.push) begin
      if (prev_ins_i) begin
        lvl_d = prev_lvl_i;
        hdl_d = prev_hdl_i;
      end else if (ins_o) begin
        lvl_d = new_lvl_i;
        hdl_d = new_hdl_i;
      end
    end else if (cmd_i.pop) begin
      lvl_d = next_lvl_i;
      hdl_d = next_hdl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q <= lvl_d;
    hdl_q <= hdl_d;
  end

  assign lvl_o = lvl_q;
  assign hdl_o = hdl_q;

endmodule

// ----- rtl/stable_priority_task_queue_core.sv -----
// ----------------------------------------------------------------------------
// stable_priority_task_queue_core
// Sorted task queue built as a chain of QUEUE_DEPTH cells kept in ascending
// level order, equal levels in arrival order. Each input word (push, pop or
// stop) is accepted on handshake and its single result word appears in the
// output register on the next cycle; a new word is accepted every cycle while
// the output side takes results. All cells compare the pushed level against
// their own entry and shift one place in the same clock edge, so that compare
// plus the neighbor shift set the cycle time, not the queue depth.
// ----------------------------------------------------------------------------
`include "stable_priority_task_queue_core_assert.svh"

module stable_priority_task_queue_core import sptq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned LEVEL_BITS  = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             opcode_i,
  input  logic [LevelPortW-1:0]  level_i,
  input  logic [HandlePortW-1:0] handle_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [2:0]             status_o,
  output logic [LevelPortW-1:0]  out_level_o,
  output logic [HandlePortW-1:0] out_handle_o,
  output logic [OccPortW-1:0]    occupancy_o
);

  localparam int unsigned LvlW = (LEVEL_BITS < LevelPortW) ? LEVEL_BITS : LevelPortW;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [LvlW-1:0]        lvl_w [QUEUE_DEPTH];
  logic [HandlePortW-1:0] hdl_w [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] ins_w;

  logic [CntW-1:0] count_q, count_d;
  logic            stopped_q, stopped_d;
  logic            out_valid_q;
  sptq_status_e    status_q, status_d;
  logic [LvlW-1:0]        out_lvl_q, out_lvl_d;
  logic [HandlePortW-1:0] out_hdl_q, out_hdl_d;

  logic            accept;
  logic            is_push, is_pop, is_stop;
  logic            full, empty;
  sptq_cmd_t       cmd;
  logic [LvlW-1:0] new_lvl;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_push    = accept && (opcode_i == OP_PUSH);
  assign is_pop     = accept && (opcode_i == OP_POP);
  assign is_stop    = accept && (opcode_i == OP_STOP);
  assign full       = (count_q >= CntW'(QUEUE_DEPTH));
  assign empty      = (count_q == '0);
  assign new_lvl    = level_i[LvlW-1:0];

  assign cmd.push = is_push && !stopped_q && !full;
  assign cmd.pop  = is_pop && !empty;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                   prev_ins;
    logic [LvlW-1:0]        prev_lvl, next_lvl;
    logic [HandlePortW-1:0] prev_hdl, next_hdl;

    if (i == 0) begin : g_first
      assign prev_ins = 1'b0;
      assign prev_lvl = '0;
      assign prev_hdl = '0;
    end else begin : g_mid
      assign prev_ins = ins_w[i-1];
      assign prev_lvl = lvl_w[i-1];
      assign prev_hdl = hdl_w[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_lvl = lvl_w[i];
      assign next_hdl = hdl_w[i];
    end else begin : g_inner
      assign next_lvl = lvl_w[i+1];
      assign next_hdl = hdl_w[i+1];
    end

    sptq_cell #(
      .LEVEL_W(LvlW),
      .CNT_W  (CntW),
      .INDEX  (i)
    ) u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .count_i   (count_q),
      .new_lvl_i (new_lvl),
      .new_hdl_i (handle_i),
      .prev_ins_i(prev_ins),
      .prev_lvl_i(prev_lvl),
      .prev_hdl_i(prev_hdl),
      .next_lvl_i(next_lvl),
      .next_hdl_i(next_hdl),
      .ins_o     (ins_w[i]),
      .lvl_o     (lvl_w[i]),
      .hdl_o     (hdl_w[i])
    );
  end

  always_comb begin
    count_d   = count_q;
    stopped_d = stopped_q;
    status_d  = ST_OK;
    out_lvl_d = '0;
    out_hdl_d = '0;
    if (is_push) begin
      if (stopped_q) begin
        status_d = ST_REJECTED;
      end else if (full) begin
        status_d = ST_FULL;
      end else begin
        count_d = count_q + 1'b1;
      end
    end else if (is_pop) begin
      if (empty) begin
        status_d = stopped_q ? ST_DRAINED : ST_EMPTY;
      end else begin
        out_lvl_d = lvl_w[0];
        out_hdl_d = hdl_w[0];
        count_d   = count_q - 1'b1;
      end
    end else if (is_stop) begin
      stopped_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      stopped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      stopped_q <= stopped_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      out_lvl_q <= out_lvl_d;
      out_hdl_q <= out_hdl_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign out_level_o  = LevelPortW'(out_lvl_q);
  assign out_handle_o = out_hdl_q;
  assign occupancy_o  = OccPortW'(count_q);

  `SPTQ_ASSERT(a_count_bound, count_q <= CntW'(QUEUE_DEPTH), "entry count above depth")
  `SPTQ_ASSERT_NEXT(a_stop_sticky, stopped_q, stopped_q, "stop flag cleared")
  `SPTQ_ASSERT_NEXT(a_pop_shrinks, cmd.pop, (count_q + 1'b1 == $past(count_q)) && (status_q == ST_OK), "pop did not remove one entry")
  `SPTQ_ASSERT_NEXT(a_reject_hold, is_push && stopped_q, (status_q == ST_REJECTED) && $stable(count_q), "push after stop changed queue")
  `SPTQ_ASSERT(a_front_sorted, (count_q < CntW'(2)) || (lvl_w[0] <= lvl_w[1]), "front entries out of order")

endmodule
